// ===== hw/rtl/rdhc_pkg.sv =====
// Shared types, codes and constants of the frame deframer and header checker.
`default_nettype none

package rdhc_pkg;

  localparam int LenBytes   = 4;
  localparam int HdrBytes   = 16;
  localparam int HdrVerOff  = 4;
  localparam int HdrTypeOff = 6;
  localparam int HdrRidOff  = 8;

  localparam logic [31:0] MagicReset   = 32'd0;
  localparam logic [15:0] VersionReset = 16'd1;
  localparam logic [31:0] MaxLenReset  = 32'd1048576;

  localparam logic [1:0] KIND_HDR  = 2'd0;
  localparam logic [1:0] KIND_BODY = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  localparam logic [1:0] ERR_LEN_BIG = 2'd0;
  localparam logic [1:0] ERR_SHORT   = 2'd1;
  localparam logic [1:0] ERR_MAGIC   = 2'd2;
  localparam logic [1:0] ERR_VERSION = 2'd3;

  localparam logic [1:0] CFG_MAGIC   = 2'd0;
  localparam logic [1:0] CFG_VERSION = 2'd1;
  localparam logic [1:0] CFG_MAX_LEN = 2'd2;

  typedef enum logic [2:0] {
    PH_LEN,
    PH_HDR,
    PH_BODY,
    PH_DISCARD,
    PH_STUCK
  } phase_t;

  typedef struct packed {
    logic [31:0] magic;
    logic [15:0] version;
    logic [31:0] max_len;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] msg_type;
    logic [63:0] req_id;
    logic [31:0] body_len;
    logic [7:0]  body_byte;
    logic        last;
    logic [1:0]  error_code;
  } res_t;

  function automatic res_t err_res(input logic [1:0] code);
    res_t r;
    r            = '0;
    r.kind       = KIND_ERR;
    r.last       = 1'b1;
    r.error_code = code;
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/rdhc_core.sv =====
// Frame parser: length field, header capture and check, body byte results.
`default_nettype none

module rdhc_core (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_fire,
  input  wire logic [7:0]    in_byte,
  input  rdhc_pkg::cfg_t     cfg,
  output logic               res_valid,
  output rdhc_pkg::res_t     res
);
  import rdhc_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [31:0] count_r, count_nxt;
  logic [31:0] len_r, len_nxt;
  logic [31:0] last_idx_r, last_idx_nxt;
  logic [31:0] body_len_r, body_len_nxt;
  logic [31:0] magic_r, magic_nxt;
  logic [15:0] version_r, version_nxt;
  logic [15:0] type_r, type_nxt;
  logic [63:0] reqid_r, reqid_nxt;

  logic [31:0] len_new;
  logic [63:0] reqid_new;
  logic [31:0] count_inc;
  logic [3:0]  hdr_pos;
  logic        len_done;
  logic        len_big;
  logic        len_zero;
  logic        frame_end;
  logic        hdr_done;
  logic        bad_magic;
  logic        bad_version;

  assign len_new     = {in_byte, len_r[31:8]};
  assign reqid_new   = {in_byte, reqid_r[63:8]};
  assign count_inc   = count_r + 32'd1;
  assign hdr_pos     = count_r[3:0];
  assign len_done    = (count_r[1:0] == 2'(LenBytes - 1));
  assign len_big     = (len_new > cfg.max_len);
  assign len_zero    = (len_new == 32'd0);
  assign frame_end   = (count_r == last_idx_r);
  assign hdr_done    = (hdr_pos == 4'(HdrBytes - 1));
  assign bad_magic   = (magic_r != cfg.magic);
  assign bad_version = (version_r != cfg.version);

  always_comb begin
    phase_nxt    = phase_r;
    count_nxt    = count_r;
    len_nxt      = len_r;
    last_idx_nxt = last_idx_r;
    body_len_nxt = body_len_r;
    magic_nxt    = magic_r;
    version_nxt  = version_r;
    type_nxt     = type_r;
    reqid_nxt    = reqid_r;
    if (in_fire) begin
      case (phase_r)
        PH_LEN: begin
          len_nxt   = len_new;
          count_nxt = count_inc;
          if (len_done) begin
            count_nxt = 32'd0;
            if (len_big) begin
              phase_nxt = PH_STUCK;
            end else if (!len_zero) begin
              phase_nxt    = PH_HDR;
              last_idx_nxt = len_new - 32'd1;
              body_len_nxt = len_new - 32'(HdrBytes);
            end
          end
        end
        PH_HDR: begin
          if (hdr_pos < 4'(HdrVerOff)) begin
            magic_nxt = {in_byte, magic_r[31:8]};
          end else if (hdr_pos < 4'(HdrTypeOff)) begin
            version_nxt = {in_byte, version_r[15:8]};
          end else if (hdr_pos < 4'(HdrRidOff)) begin
            type_nxt = {in_byte, type_r[15:8]};
          end else begin
            reqid_nxt = reqid_new;
          end
          if (frame_end) begin
            phase_nxt = PH_LEN;
            count_nxt = 32'd0;
          end else begin
            count_nxt = count_inc;
            if (hdr_done) begin
              phase_nxt = (bad_magic || bad_version) ? PH_DISCARD : PH_BODY;
            end
          end
        end
        PH_BODY, PH_DISCARD: begin
          if (frame_end) begin
            phase_nxt = PH_LEN;
            count_nxt = 32'd0;
          end else begin
            count_nxt = count_inc;
          end
        end
        default: begin
          phase_nxt = phase_r;
        end
      endcase
    end
  end

  always_comb begin
    res_valid = 1'b0;
    res       = '0;
    if (in_fire) begin
      case (phase_r)
        PH_LEN: begin
          if (len_done && len_big) begin
            res_valid = 1'b1;
            res       = err_res(ERR_LEN_BIG);
          end else if (len_done && len_zero) begin
            res_valid = 1'b1;
            res       = err_res(ERR_SHORT);
          end
        end
        PH_HDR: begin
          if (!hdr_done && frame_end) begin
            res_valid = 1'b1;
            res       = err_res(ERR_SHORT);
          end else if (hdr_done && bad_magic) begin
            res_valid = 1'b1;
            res       = err_res(ERR_MAGIC);
          end else if (hdr_done && bad_version) begin
            res_valid = 1'b1;
            res       = err_res(ERR_VERSION);
          end else if (hdr_done) begin
            res_valid     = 1'b1;
            res.kind      = KIND_HDR;
            res.msg_type  = type_r;
            res.req_id    = reqid_new;
            res.body_len  = body_len_r;
            res.last      = frame_end;
          end
        end
        PH_BODY: begin
          res_valid     = 1'b1;
          res.kind      = KIND_BODY;
          res.msg_type  = type_r;
          res.req_id    = reqid_r;
          res.body_len  = body_len_r;
          res.body_byte = in_byte;
          res.last      = frame_end;
        end
        default: begin
          res_valid = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_LEN;
      count_r <= 32'd0;
    end else begin
      phase_r <= phase_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    len_r      <= len_nxt;
    last_idx_r <= last_idx_nxt;
    body_len_r <= body_len_nxt;
    magic_r    <= magic_nxt;
    version_r  <= version_nxt;
    type_r     <= type_nxt;
    reqid_r    <= reqid_nxt;
  end

  a_stuck_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_STUCK) |-> !res_valid)
    else $error("result while stuck after length error");

  a_hdr_count: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_HDR) |-> (count_r < 32'(HdrBytes)))
    else $error("header byte count out of range");

  a_len_big_stuck: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res.kind == KIND_ERR && res.error_code == ERR_LEN_BIG)
      |=> (phase_r == PH_STUCK))
    else $error("length error did not stop the stream");

endmodule

`default_nettype wire

// ===== hw/rtl/rdhc_obuf.sv =====
// Output register with skid stage for result items.
`default_nettype none

module rdhc_obuf (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          res_valid,
  input  rdhc_pkg::res_t     res,
  output logic               in_stall,
  output logic               out_valid,
  input  wire logic          out_stall,
  output rdhc_pkg::res_t     out_res
);
  import rdhc_pkg::*;

  logic out_valid_r, out_valid_nxt;
  logic skid_valid_r, skid_valid_nxt;
  res_t out_res_r, out_res_nxt;
  res_t skid_res_r, skid_res_nxt;
  logic out_fire;

  assign out_fire  = out_valid_r && !out_stall;
  assign in_stall  = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_res_nxt    = out_res_r;
    skid_res_nxt   = skid_res_r;
    if (skid_valid_r) begin
      if (out_fire) begin
        out_res_nxt    = skid_res_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (res_valid) begin
      if (!out_valid_r || out_fire) begin
        out_res_nxt   = res;
        out_valid_nxt = 1'b1;
      end else begin
        skid_res_nxt   = res;
        skid_valid_nxt = 1'b1;
      end
    end else if (out_fire) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r  <= out_res_nxt;
    skid_res_r <= skid_res_nxt;
  end

  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid holds an item while output register is empty");

  a_no_write_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> !res_valid)
    else $error("result arrived while skid stage full");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!out_valid_r && !skid_valid_r))
    else $error("buffer not empty after reset");

endmodule

`default_nettype wire

// ===== hw/rtl/rpc_deframer_header_checker_top.sv =====
// Top level of the length-prefixed frame deframer with RPC header check.
// A result goes to the output register, or to the skid stage if that is held.
// Throughput: one input item per cycle while in_stall is low; the output register
// plus skid stage keep the input open while one finished result waits.
// Reset (rst_n, synchronous): parser returns to the length field, buffers empty,
// config takes its defaults; an oversize length silences the parser until reset.
`default_nettype none

module rpc_deframer_header_checker_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_kind,
  output logic [15:0]      out_msg_type,
  output logic [63:0]      out_req_id,
  output logic [31:0]      out_body_len,
  output logic [7:0]       out_body_byte,
  output logic             out_last,
  output logic [1:0]       out_error_code,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_wdata
);
  import rdhc_pkg::*;

  cfg_t cfg_r, cfg_nxt;
  logic in_fire;
  logic res_valid;
  res_t res;
  res_t out_res;

  assign in_fire = in_valid && !in_stall;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_MAGIC:   cfg_nxt.magic   = cfg_wdata;
        CFG_VERSION: cfg_nxt.version = cfg_wdata[15:0];
        CFG_MAX_LEN: cfg_nxt.max_len = cfg_wdata;
        default:     cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.magic   <= MagicReset;
      cfg_r.version <= VersionReset;
      cfg_r.max_len <= MaxLenReset;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  rdhc_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .in_byte   (in_byte),
    .cfg       (cfg_r),
    .res_valid (res_valid),
    .res       (res)
  );

  rdhc_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_kind       = out_res.kind;
  assign out_msg_type   = out_res.msg_type;
  assign out_req_id     = out_res.req_id;
  assign out_body_len   = out_res.body_len;
  assign out_body_byte  = out_res.body_byte;
  assign out_last       = out_res.last;
  assign out_error_code = out_res.error_code;

  a_err_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == KIND_ERR) |-> (out_last && out_req_id == 64'd0))
    else $error("error item not final or carries header fields");

  a_code_only_on_err: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind != KIND_ERR) |-> (out_error_code == ERR_LEN_BIG))
    else $error("error code set on non-error item");

  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_kind == KIND_HDR || out_kind == KIND_BODY || out_kind == KIND_ERR))
    else $error("unknown item kind");

endmodule

`default_nettype wire
